[sv/utf8_codepoint_stream_search_top_defines.svh]
// ---------------------------------------------------------------------------
// utf8 code point stream search: assertion macros
// concurrent checks sampled on clock, disabled in reset
// ---------------------------------------------------------------------------
`ifndef UTF8_CODEPOINT_STREAM_SEARCH_TOP_DEFINES_SVH
`define UTF8_CODEPOINT_STREAM_SEARCH_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define U8S_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same cycle implication");
`define U8S_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next cycle implication");
`else
`define U8S_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define U8S_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

[sv/utf8cs_pkg.sv]
// ---------------------------------------------------------------------------
// utf8cs_pkg
// shared widths, register map and the utf8 encoder
// ---------------------------------------------------------------------------
`default_nettype none

package utf8cs_pkg;

   localparam int OFFSET_WIDTH   = 32;
   localparam int CP_WIDTH       = 21;
   localparam int BYTE_WIDTH     = 8;
   localparam int PATTERN_BYTES  = 4;
   localparam int PATTERN_WIDTH  = PATTERN_BYTES * BYTE_WIDTH;
   localparam int WINDOW_WIDTH   = (PATTERN_BYTES - 1) * BYTE_WIDTH;
   localparam int RESULT_WIDTH   = 32;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_IDX_WIDTH  = CSR_ADDR_WIDTH - 2;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_IDX_TARGET_CODE_POINT = '0;

   localparam logic [OFFSET_WIDTH-1:0] COUNT_MAX = '1;

   localparam logic [CP_WIDTH-1:0] LIMIT_ONE_BYTE   = CP_WIDTH'(32'h80);
   localparam logic [CP_WIDTH-1:0] LIMIT_TWO_BYTE   = CP_WIDTH'(32'h0800);
   localparam logic [CP_WIDTH-1:0] LIMIT_THREE_BYTE = CP_WIDTH'(32'h10000);

   localparam logic [7:0] LEAD_TWO   = 8'hC0;
   localparam logic [7:0] LEAD_THREE = 8'hE0;
   localparam logic [7:0] LEAD_FOUR  = 8'hF0;
   localparam logic [7:0] CONT_MARK  = 8'h80;

   typedef struct packed {
      logic [1:0]               len_m1;
      logic [PATTERN_WIDTH-1:0] pattern;
   } encoding_type;

   function automatic encoding_type encode_utf8(input logic [CP_WIDTH-1:0] cp);
      encoding_type enc;
      logic [7:0]   c0;
      logic [7:0]   c1;
      logic [7:0]   c2;
      c0 = CONT_MARK | {2'b00, cp[5:0]};
      c1 = CONT_MARK | {2'b00, cp[11:6]};
      c2 = CONT_MARK | {2'b00, cp[17:12]};
      if (cp < LIMIT_ONE_BYTE) begin
         enc.len_m1  = 2'd0;
         enc.pattern = {25'b0, cp[6:0]};
      end else if (cp < LIMIT_TWO_BYTE) begin
         enc.len_m1  = 2'd1;
         enc.pattern = {16'b0, LEAD_TWO | {3'b000, cp[10:6]}, c0};
      end else if (cp < LIMIT_THREE_BYTE) begin
         enc.len_m1  = 2'd2;
         enc.pattern = {8'b0, LEAD_THREE | {4'b0000, cp[15:12]}, c1, c0};
      end else begin
         enc.len_m1  = 2'd3;
         enc.pattern = {LEAD_FOUR | {5'b00000, cp[20:18]}, c2, c1, c0};
      end
      return enc;
   endfunction

endpackage

`default_nettype wire

[sv/utf8cs_if.sv]
// ---------------------------------------------------------------------------
// utf8cs channel interfaces
// valid/ready channels for text bytes and search results
// ---------------------------------------------------------------------------
`default_nettype none

interface utf8cs_req_if;
   import utf8cs_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [BYTE_WIDTH-1:0] data_byte;
   logic                  end_of_text;

   modport source (output valid, output data_byte, output end_of_text, input ready);
   modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

interface utf8cs_rsp_if;
   import utf8cs_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    found;
   logic [RESULT_WIDTH-1:0] match_offset;

   modport source (output valid, output found, output match_offset, input ready);
   modport sink   (input valid, input found, input match_offset, output ready);
endinterface

`default_nettype wire

[sv/utf8_codepoint_stream_search_top.sv]
// a result is captured in the result register by the byte transfer that causes it
// throughput: one byte per cycle unless a stalled result is held, the result register frees itself when it is taken
// a stalled result blocks new bytes only while the result register stays full
// reset: synchronous, clears the target (code point 0), window, count, reported and valid flags
// ---------------------------------------------------------------------------
// utf8_codepoint_stream_search_top
// searches a byte stream for the utf8 encoding of a configured code point
// ---------------------------------------------------------------------------
`default_nettype none

`include "utf8_codepoint_stream_search_top_defines.svh"

module utf8_codepoint_stream_search_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   utf8cs_req_if.sink                               req_bus,
   utf8cs_rsp_if.source                             rsp_bus,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [utf8cs_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [utf8cs_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic      [utf8cs_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                     csr_pready
);
   import utf8cs_pkg::*;

   logic [CP_WIDTH-1:0]       target_ff;
   encoding_type              enc_ff;
   logic [WINDOW_WIDTH-1:0]   recent_ff,   recent_in;
   logic [OFFSET_WIDTH-1:0]   seen_ff,     seen_in;
   logic                      reported_ff, reported_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      found_ff,    found_in;
   logic [RESULT_WIDTH-1:0]   offset_ff,   offset_in;

   logic                      csr_sel_target;
   logic                      csr_wr;
   logic                      accept;
   logic [PATTERN_WIDTH-1:0]  window;
   logic [PATTERN_BYTES-1:0]  byte_hit;
   logic [PATTERN_BYTES-1:0]  byte_used;
   logic                      enough;
   logic                      hit;
   logic                      result;
   logic [OFFSET_WIDTH-1:0]   offset;
   logic [OFFSET_WIDTH+RESULT_WIDTH-1:0] offset_ext;

   // configuration port
   assign csr_sel_target = (csr_paddr[CSR_ADDR_WIDTH-1:2] == CSR_IDX_TARGET_CODE_POINT);
   assign csr_wr         = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready     = 1'b1;
   assign csr_prdata     = csr_sel_target ? CSR_DATA_WIDTH'(target_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
         enc_ff    <= '0;
      end else if (csr_wr && csr_sel_target) begin
         target_ff <= csr_pwdata[CP_WIDTH-1:0];
         enc_ff    <= encode_utf8(csr_pwdata[CP_WIDTH-1:0]);
      end
   end

   // window compare
   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign window        = {recent_ff, req_bus.data_byte};

   always_comb begin
      for (int i = 0; i < PATTERN_BYTES; i++) begin
         byte_hit[i]  = (window[i*BYTE_WIDTH +: BYTE_WIDTH] ==
                         enc_ff.pattern[i*BYTE_WIDTH +: BYTE_WIDTH]);
         byte_used[i] = (i <= int'(enc_ff.len_m1));
      end
   end

   assign enough     = (seen_ff >= OFFSET_WIDTH'(enc_ff.len_m1));
   assign hit        = !reported_ff && enough && (&(byte_hit | ~byte_used));
   assign result     = hit || (req_bus.end_of_text && !reported_ff);
   assign offset     = (seen_ff == COUNT_MAX) ? COUNT_MAX
                                              : seen_ff - OFFSET_WIDTH'(enc_ff.len_m1);
   assign offset_ext = {{RESULT_WIDTH{1'b0}}, offset};

   always_comb begin
      recent_in   = recent_ff;
      seen_in     = seen_ff;
      reported_in = reported_ff;
      if (accept) begin
         if (req_bus.end_of_text) begin
            recent_in   = '0;
            seen_in     = '0;
            reported_in = 1'b0;
         end else begin
            recent_in   = window[WINDOW_WIDTH-1:0];
            seen_in     = (seen_ff == COUNT_MAX) ? seen_ff : seen_ff + 1'b1;
            reported_in = reported_ff || hit;
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      found_in     = found_ff;
      offset_in    = offset_ff;
      if (accept) begin
         rsp_valid_in = result;
         found_in     = hit;
         offset_in    = hit ? offset_ext[RESULT_WIDTH-1:0] : '0;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recent_ff    <= '0;
         seen_ff      <= '0;
         reported_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         recent_ff    <= recent_in;
         seen_ff      <= seen_in;
         reported_ff  <= reported_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      found_ff  <= found_in;
      offset_ff <= offset_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.found        = found_ff;
   assign rsp_bus.match_offset = offset_ff;

   `U8S_ASSERT_IMP(a_notfound_zero, clock, reset, rsp_valid_ff && !found_ff, offset_ff == '0)
   `U8S_ASSERT_IMP(a_reported_enough, clock, reset, reported_ff,
                   seen_ff >= OFFSET_WIDTH'(enc_ff.len_m1))
   `U8S_ASSERT_NXT(a_rearm, clock, reset, accept && req_bus.end_of_text,
                   seen_ff == '0 && !reported_ff && recent_ff == '0)
   `U8S_ASSERT_NXT(a_count_moves, clock, reset, accept && !req_bus.end_of_text,
                   seen_ff != '0)

endmodule

`default_nettype wire

[dv/utf8_codepoint_stream_search_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// utf8_codepoint_stream_search_checker
// watches the byte, result and register transfers of the search block, keeps
// its own model of the window, byte count and match flag, and compares every
// result against the oldest outstanding prediction
// ---------------------------------------------------------------------------

module utf8_codepoint_stream_search_checker (
   input  logic                                clock,
   input  logic                                reset,
   utf8cs_req_if                               req_bus,
   utf8cs_rsp_if                               rsp_bus,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [utf8cs_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [utf8cs_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   input  logic                                csr_pready,
   output logic [2:0]                          target_len,
   output logic [31:0]                         target_pattern,
   output int                                  outstanding,
   output int                                  failures
);
   import utf8cs_pkg::*;

   typedef struct packed {
      logic                    found;
      logic [RESULT_WIDTH-1:0] match_offset;
   } search_result_type;

   logic [CP_WIDTH-1:0]     code_point;
   logic [23:0]             last_three;
   logic [OFFSET_WIDTH-1:0] text_bytes;
   logic                    reported;
   search_result_type       awaited_q[$];

   // first byte of the encoding in the most significant used byte
   function automatic void encode_code_point(input logic [CP_WIDTH-1:0] cp,
                                             output logic [2:0] n,
                                             output logic [31:0] bytes);
      if (cp < 21'h80) begin
         n     = 3'd1;
         bytes = {11'b0, cp};
      end else if (cp < 21'h800) begin
         n     = 3'd2;
         bytes = {16'h0, 3'b110, cp[10:6], 2'b10, cp[5:0]};
      end else if (cp < 21'h10000) begin
         n     = 3'd3;
         bytes = {8'h0, 4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
      end else begin
         n     = 3'd4;
         bytes = {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
      end
   endfunction

   always_comb encode_code_point(code_point, target_len, target_pattern);

   function automatic void take_text_byte(input logic [7:0] b, input logic last);
      logic [2:0]        n;
      logic [31:0]       pat;
      logic [31:0]       window;
      logic [31:0]       mask;
      search_result_type res;
      encode_code_point(code_point, n, pat);
      window = {last_three, b};
      mask   = (n == 3'd4) ? 32'hFFFF_FFFF : ((32'h1 << (8 * n)) - 32'h1);
      if (!reported && text_bytes >= OFFSET_WIDTH'(n - 3'd1) && (window & mask) == pat) begin
         res.found        = 1'b1;
         res.match_offset = (text_bytes == COUNT_MAX) ? RESULT_WIDTH'(COUNT_MAX) :
                            RESULT_WIDTH'(text_bytes - OFFSET_WIDTH'(n - 3'd1));
         awaited_q.push_back(res);
         reported = 1'b1;
      end
      if (last) begin
         if (!reported) begin
            res = '0;
            awaited_q.push_back(res);
         end
         last_three = '0;
         text_bytes = '0;
         reported   = 1'b0;
      end else begin
         last_three = window[23:0];
         if (text_bytes != COUNT_MAX) text_bytes = text_bytes + 1'b1;
      end
   endfunction

   always @(posedge clock) begin : watch
      search_result_type got;
      search_result_type want;
      if (reset) begin
         code_point = '0;
         last_three = '0;
         text_bytes = '0;
         reported   = 1'b0;
         failures   = 0;
         awaited_q.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.found        = rsp_bus.found;
            got.match_offset = rsp_bus.match_offset;
            if (awaited_q.size() == 0) begin
               failures++;
               $display("%0t: unexpected result, expected none, actual found=%0b offset=%0d",
                        $time, got.found, got.match_offset);
            end else begin
               want = awaited_q.pop_front();
               if (got.found !== want.found) begin
                  failures++;
                  $display("%0t: found mismatch, expected %0b, actual %0b",
                           $time, want.found, got.found);
               end
               if (got.match_offset !== want.match_offset) begin
                  failures++;
                  $display("%0t: match_offset mismatch, expected %0d, actual %0d",
                           $time, want.match_offset, got.match_offset);
               end
            end
         end
         if (req_bus.valid && req_bus.ready)
            take_text_byte(req_bus.data_byte, req_bus.end_of_text);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[CSR_ADDR_WIDTH-1:2] == CSR_IDX_TARGET_CODE_POINT)
            code_point = csr_pwdata[CP_WIDTH-1:0];
      end
      outstanding = awaited_q.size();
   end

endmodule

[dv/utf8_codepoint_stream_search_top_test.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// utf8_codepoint_stream_search_top_test
// drives texts built around the encoding of a series of target code points,
// with bursty byte transfers and a stalling result side; the checker beside
// the block predicts and compares every result
// ---------------------------------------------------------------------------

module utf8_codepoint_stream_search_top_test;
   import utf8cs_pkg::*;

   logic                      clock;
   logic                      reset;
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;
   logic [2:0]                target_len;
   logic [31:0]               target_pattern;
   int                        outstanding;
   int                        failures;

   int unsigned               bytes_sent;
   int unsigned               burst_left;
   logic [7:0]                text_q[$];

   utf8cs_req_if req_bus();
   utf8cs_rsp_if rsp_bus();

   utf8_codepoint_stream_search_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   utf8_codepoint_stream_search_checker search_check (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .target_len     (target_len),
      .target_pattern (target_pattern),
      .outstanding    (outstanding),
      .failures       (failures)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("utf8_codepoint_stream_search_top_test failed");
      $finish;
   end

   // result side: runs of steady ready, light stalls and heavy stalls
   initial begin : result_stalls
      int unsigned run_left;
      int unsigned mode;
      rsp_bus.ready <= 1'b1;
      run_left = 0;
      mode     = 0;
      forever begin
         @(posedge clock);
         if (run_left == 0) begin
            run_left = $urandom_range(5, 60);
            mode     = $urandom_range(0, 2);
         end
         run_left--;
         case (mode)
            0:       rsp_bus.ready <= 1'b1;
            1:       rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_bus.ready <= ($urandom_range(0, 2) == 0);
         endcase
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      if (burst_left == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200) :
                                                    $urandom_range(1, 30);
      end
      req_bus.valid       <= 1'b1;
      req_bus.data_byte   <= b;
      req_bus.end_of_text <= last;
      do @(posedge clock); while (!req_bus.ready);
      burst_left--;
      bytes_sent++;
   endtask

   task automatic send_text();
      for (int i = 0; i < text_q.size(); i++)
         send_byte(text_q[i], i == text_q.size() - 1);
   endtask

   // waits out outstanding results and the result register
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_target(input logic [CP_WIDTH-1:0] cp);
      logic [31:0] junk;
      junk = $urandom;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {CSR_IDX_TARGET_CODE_POINT, 2'b00};
      csr_pwdata  <= {junk[31:CP_WIDTH], cp};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [CP_WIDTH-1:0] pick_code_point();
      logic [CP_WIDTH-1:0] corners [11] = '{21'h0, 21'h7F, 21'h80, 21'h7FF, 21'h800,
                                            21'hD800, 21'hDFFF, 21'hFFFF, 21'h10000,
                                            21'h10FFFF, 21'h1FFFFF};
      case ($urandom_range(0, 5))
         0:       return corners[$urandom_range(0, 10)];
         1:       return CP_WIDTH'($urandom_range(0, 'h7F));
         2:       return CP_WIDTH'($urandom_range('h80, 'h7FF));
         3:       return CP_WIDTH'($urandom_range('h800, 'hFFFF));
         4:       return CP_WIDTH'($urandom_range('h10000, 'h10FFFF));
         default: return CP_WIDTH'($urandom_range('h110000, 'h1FFFFF));
      endcase
   endfunction

   function automatic logic [7:0] encoding_byte(input int k);
      return 8'(target_pattern >> (8 * (int'(target_len) - 1 - k)));
   endfunction

   // mostly encodings, fragments of them and stray bytes; some pure noise
   task automatic make_text();
      int unsigned n;
      int unsigned len;
      int unsigned j;
      bit          noise;
      n     = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
      noise = ($urandom_range(0, 4) == 0);
      len   = 32'(target_len);
      text_q.delete();
      while (text_q.size() < n) begin
         case (noise ? 5 : $urandom_range(0, 9))
            0, 1, 2: for (int k = 0; k < len; k++) text_q.push_back(encoding_byte(k));
            3: begin
               j = $urandom_range(1, len);
               for (int k = 0; k < j; k++) text_q.push_back(encoding_byte(k));
            end
            4: begin
               j = $urandom_range(1, len);
               for (int k = j; k < len; k++) text_q.push_back(encoding_byte(k));
            end
            5, 6:    text_q.push_back(8'($urandom_range(0, 255)));
            7:       text_q.push_back(8'h80 | 8'($urandom_range(0, 63)));
            8:       text_q.push_back(8'($urandom_range(0, 127)));
            default: text_q.push_back(8'($urandom_range('hC0, 'hFF)));
         endcase
      end
      while (text_q.size() > n) void'(text_q.pop_back());
   endtask

   initial begin : stimulus
      int unsigned random_start;
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.data_byte   <= '0;
      req_bus.end_of_text <= 1'b0;
      csr_psel            <= 1'b0;
      csr_penable         <= 1'b0;
      csr_pwrite          <= 1'b0;
      csr_paddr           <= '0;
      csr_pwdata          <= '0;
      bytes_sent = 0;
      burst_left = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // code point zero from reset: match then ignored bytes, then a bare miss
      text_q = '{8'h00, 8'hFF, 8'h00};
      send_text();
      text_q = '{8'hFF};
      send_text();
      drain();
      write_target(21'h1FFFFF);
      text_q = '{8'hF7, 8'hBF, 8'hBF, 8'hBF};
      send_text();
      text_q = '{8'hBF, 8'hBF, 8'hBF};
      send_text();
      drain();
      write_target(21'h800);
      text_q = '{8'h41, 8'hE0, 8'hA0, 8'h80, 8'hE0, 8'hA0, 8'h80};
      send_text();
      drain();
      write_target(21'h7F);
      text_q = '{8'h7F};
      send_text();
      drain();
      // lead byte too near the end of the text
      write_target(21'h10000);
      text_q = '{8'hF0, 8'h90, 8'h80};
      send_text();

      random_start = bytes_sent;
      while (bytes_sent - random_start < 1900) begin
         drain();
         write_target(pick_code_point());
         repeat ($urandom_range(3, 8)) begin
            make_text();
            send_text();
         end
      end

      drain();
      if (failures == 0 && outstanding == 0)
         $display("utf8_codepoint_stream_search_top_test passed");
      else
         $display("utf8_codepoint_stream_search_top_test failed");
      $finish;
   end

endmodule
